// ----- rtl/core/flat_json_object_tokenizer_assert.svh -----
// Assertion macros for the flat JSON object tokenizer.
// Included by the top level; no other dependencies.
`ifndef FLAT_JSON_OBJECT_TOKENIZER_ASSERT_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define FJOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FJOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FJOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FJOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/fjot_pkg.sv -----
// Shared types, codes and character constants of the JSON object tokenizer.
// No dependencies.
package fjot_pkg;

  localparam logic [7:0] ROW_LIMIT = 8'd128;
  localparam logic [7:0] MAX_ROWS_RESET = 8'd128;

  localparam logic [2:0] PH_OUTSIDE   = 3'd0;
  localparam logic [2:0] PH_KEY       = 3'd1;
  localparam logic [2:0] PH_AFTER_KEY = 3'd2;
  localparam logic [2:0] PH_COLON     = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;
  localparam logic [2:0] PH_AFTER_STR = 3'd5;

  localparam logic [1:0] NUM_IDLE   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_SPACES = 2'd2;

  localparam logic [2:0] K_NONE   = 3'd0;
  localparam logic [2:0] K_KEYCH  = 3'd1;
  localparam logic [2:0] K_KEYEND = 3'd2;
  localparam logic [2:0] K_VALCH  = 3'd3;
  localparam logic [2:0] K_STREND = 3'd4;
  localparam logic [2:0] K_NUMEND = 3'd5;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [2:0] phase;
    logic       esc;
    logic       in_num;
    logic [1:0] num_sub;
    logic       dot;
    logic [7:0] row_cnt;
    logic       halted;
    logic       err;
  } fjot_state_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_char;
    logic [6:0] row_index;
    logic [7:0] rows_found;
    logic       parse_error;
    logic       finished;
  } fjot_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- rtl/core/fjot_in_if.sv -----
// Input channel of the JSON object tokenizer: one text byte per item.
// No dependencies.
interface fjot_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- rtl/core/fjot_out_if.sv -----
// Result channel of the JSON object tokenizer: one token event per item.
// No dependencies.
interface fjot_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_char;
  logic [6:0] row_index;
  logic [7:0] rows_found;
  logic       parse_error;
  logic       finished;

  modport source (output valid, output token_kind, output token_char, output row_index,
                  output rows_found, output parse_error, output finished, input ready);
  modport sink (input valid, input token_kind, input token_char, input row_index,
                input rows_found, input parse_error, input finished, output ready);
endinterface

// ----- rtl/core/flat_json_object_tokenizer.sv -----
// Top level of the flat JSON object tokenizer: input register, parse state, result register.
// Depends on fjot_pkg, fjot_in_if, fjot_out_if, fjot_step and the assertion macro header.
//
//   channel   direction  payload                                       handshake
//   in_ch     in         text_byte, end_of_text                        valid/ready
//   out_ch    out        token_kind, token_char, row_index, rows_found,
//                        parse_error, finished                         valid/ready
//   cfg       in         cfg_data (max_rows)                           cfg_we, no ready
//
// Each item passes through the input register and then the result register; one item is accepted every cycle
// while the result is not stalled. The byte is parsed as it moves from the input register to the result register.
// A stalled result holds the input register, and the input accepts again as soon as it drains.
// Reset clears the parse state and sets max_rows to 128.
`include "flat_json_object_tokenizer_assert.svh"

module flat_json_object_tokenizer (
  input  logic             clk,
  input  logic             rst_n,
  fjot_in_if.sink          in_ch,
  fjot_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data
);

  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic                   in_eot_r;
  logic                   out_vld_r;
  fjot_pkg::fjot_result_t out_res_r;
  fjot_pkg::fjot_state_t  state_r;
  fjot_pkg::fjot_state_t  state_nxt;
  fjot_pkg::fjot_result_t res_nxt;
  logic [7:0]             max_rows_r;
  logic [7:0]             limit;
  logic                   out_free;
  logic                   advance;

  assign limit    = (max_rows_r > fjot_pkg::ROW_LIMIT) ? fjot_pkg::ROW_LIMIT : max_rows_r;
  assign out_free = !out_vld_r || out_ch.ready;
  assign advance  = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || out_free;

  fjot_step u_step (
    .state_i (state_r),
    .byte_i  (in_byte_r),
    .eot_i   (in_eot_r),
    .limit_i (limit),
    .state_o (state_nxt),
    .res_o   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      state_r    <= '0;
      max_rows_r <= fjot_pkg::MAX_ROWS_RESET;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        max_rows_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.text_byte;
      in_eot_r  <= in_ch.end_of_text;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.token_kind  = out_res_r.token_kind;
  assign out_ch.token_char  = out_res_r.token_char;
  assign out_ch.row_index   = out_res_r.row_index;
  assign out_ch.rows_found  = out_res_r.rows_found;
  assign out_ch.parse_error = out_res_r.parse_error;
  assign out_ch.finished    = out_res_r.finished;

  `FJOT_ASSERT_IMP(a_row_bound, clk, rst_n, 1'b1, state_r.row_cnt <= fjot_pkg::ROW_LIMIT, "row count above limit")
  `FJOT_ASSERT_IMP(a_err_no_token, clk, rst_n, out_vld_r && out_res_r.parse_error, out_res_r.token_kind == fjot_pkg::K_NONE, "token emitted with error set")
  `FJOT_ASSERT_NXT(a_halt_hold, clk, rst_n, advance && state_r.halted && !in_eot_r, $stable(state_r), "halted state changed")

endmodule

// ----- rtl/core/fjot_step.sv -----
// Next-state and token logic for one text byte of the tokenizer.
// Depends on fjot_pkg.
module fjot_step (
  input  fjot_pkg::fjot_state_t  state_i,
  input  logic [7:0]             byte_i,
  input  logic                   eot_i,
  input  logic [7:0]             limit_i,
  output fjot_pkg::fjot_state_t  state_o,
  output fjot_pkg::fjot_result_t res_o
);

  fjot_pkg::fjot_state_t st;
  logic [2:0] kind;
  logic [7:0] ch;
  logic       fail;
  logic       closed;

  always_comb begin
    st     = state_i;
    kind   = fjot_pkg::K_NONE;
    ch     = 8'd0;
    fail   = 1'b0;
    closed = 1'b0;
    if (!state_i.halted) begin
      unique case (state_i.phase)
        fjot_pkg::PH_OUTSIDE: begin
          if (byte_i == fjot_pkg::CH_QUOTE) begin
            if (state_i.row_cnt >= limit_i) begin
              fail = 1'b1;
            end else begin
              st.phase = fjot_pkg::PH_KEY;
            end
          end else if (byte_i != fjot_pkg::CH_SPACE && byte_i != fjot_pkg::CH_LBRACE &&
                       byte_i != fjot_pkg::CH_RBRACE) begin
            fail = 1'b1;
          end
        end
        fjot_pkg::PH_KEY: begin
          if (state_i.esc) begin
            st.esc = 1'b0;
            kind   = fjot_pkg::K_KEYCH;
            ch     = byte_i;
          end else if (byte_i == fjot_pkg::CH_BSLASH) begin
            st.esc = 1'b1;
          end else if (byte_i == fjot_pkg::CH_QUOTE) begin
            st.phase = fjot_pkg::PH_AFTER_KEY;
            kind     = fjot_pkg::K_KEYEND;
          end else begin
            kind = fjot_pkg::K_KEYCH;
            ch   = byte_i;
          end
        end
        fjot_pkg::PH_AFTER_KEY: begin
          if (byte_i == fjot_pkg::CH_COLON) begin
            st.phase = fjot_pkg::PH_COLON;
          end else if (byte_i != fjot_pkg::CH_SPACE) begin
            fail = 1'b1;
          end
        end
        fjot_pkg::PH_COLON: begin
          if (byte_i == fjot_pkg::CH_QUOTE) begin
            st.phase  = fjot_pkg::PH_VALUE;
            st.in_num = 1'b0;
          end else if (byte_i == fjot_pkg::CH_MINUS || fjot_pkg::is_digit(byte_i)) begin
            st.phase   = fjot_pkg::PH_VALUE;
            st.in_num  = 1'b1;
            st.num_sub = fjot_pkg::NUM_DIGITS;
            st.dot     = 1'b0;
            kind       = fjot_pkg::K_VALCH;
            ch         = byte_i;
          end else if (byte_i == fjot_pkg::CH_BSLASH || byte_i == fjot_pkg::CH_COLON ||
                       byte_i == fjot_pkg::CH_COMMA) begin
            fail = 1'b1;
          end
        end
        fjot_pkg::PH_VALUE: begin
          if (!state_i.in_num) begin
            if (state_i.esc) begin
              st.esc = 1'b0;
              kind   = fjot_pkg::K_VALCH;
              ch     = byte_i;
            end else if (byte_i == fjot_pkg::CH_BSLASH) begin
              st.esc = 1'b1;
            end else if (byte_i == fjot_pkg::CH_QUOTE) begin
              st.phase   = fjot_pkg::PH_AFTER_STR;
              kind       = fjot_pkg::K_STREND;
              st.row_cnt = state_i.row_cnt + 8'd1;
            end else begin
              kind = fjot_pkg::K_VALCH;
              ch   = byte_i;
            end
          end else if (byte_i == fjot_pkg::CH_COMMA) begin
            st.phase   = fjot_pkg::PH_OUTSIDE;
            st.in_num  = 1'b0;
            kind       = fjot_pkg::K_NUMEND;
            st.row_cnt = state_i.row_cnt + 8'd1;
          end else if (state_i.num_sub == fjot_pkg::NUM_DIGITS) begin
            if (byte_i == fjot_pkg::CH_DOT && !state_i.dot) begin
              st.dot = 1'b1;
              kind   = fjot_pkg::K_VALCH;
              ch     = byte_i;
            end else if (fjot_pkg::is_digit(byte_i)) begin
              kind = fjot_pkg::K_VALCH;
              ch   = byte_i;
            end else if (byte_i == fjot_pkg::CH_SPACE) begin
              st.num_sub = fjot_pkg::NUM_SPACES;
            end else if (byte_i == fjot_pkg::CH_RBRACE) begin
              kind       = fjot_pkg::K_NUMEND;
              st.row_cnt = state_i.row_cnt + 8'd1;
              closed     = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end else if (byte_i != fjot_pkg::CH_SPACE) begin
            fail = 1'b1;
          end
        end
        fjot_pkg::PH_AFTER_STR: begin
          if (byte_i == fjot_pkg::CH_COMMA) begin
            st.phase = fjot_pkg::PH_OUTSIDE;
          end else if (byte_i == fjot_pkg::CH_RBRACE) begin
            closed = 1'b1;
          end else if (byte_i != fjot_pkg::CH_SPACE) begin
            fail = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (fail) begin
        st.err    = 1'b1;
        st.halted = 1'b1;
        kind      = fjot_pkg::K_NONE;
        ch        = 8'd0;
      end
      if (closed) begin
        st.halted = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.token_kind  = kind;
    res_o.token_char  = ch;
    res_o.row_index   = (kind == fjot_pkg::K_NONE) ? 7'd0 : state_i.row_cnt[6:0];
    res_o.rows_found  = st.row_cnt;
    res_o.parse_error = st.err;
    res_o.finished    = (st.halted && !st.err) || eot_i;
    state_o           = eot_i ? '0 : st;
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the flat JSON object tokenizer: feeds JSON text one byte per item,
// predicts every token event and compares it field by field with the block's results.
// Depends on fjot_pkg, fjot_in_if, fjot_out_if and the flat_json_object_tokenizer top level.
module testbench;
  import fjot_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 200;

  typedef struct packed {
    logic       is_setting;
    logic [7:0] data;
    logic       eot;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_data;

  fjot_in_if in_ch();
  fjot_out_if out_ch();

  flat_json_object_tokenizer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  text_item_t text_queue[$];
  fjot_result_t expected_tokens[$];
  logic [7:0] draft[$];

  logic [2:0] parse_phase;
  logic       esc_armed;
  logic       num_active;
  logic [1:0] num_stage;
  logic       dot_taken;
  logic [7:0] rows_done;
  logic       stopped;
  logic       err_flag;
  logic [7:0] row_cap;

  int fail_count = 0;
  int items_left = 0;
  int results_taken = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int recv_hold = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic drv_valid;
  logic drv_we;
  logic next_ready;
  fjot_result_t got;
  fjot_result_t want;

  task automatic flag_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic void clear_parse_state();
    parse_phase = PH_OUTSIDE;
    esc_armed = 1'b0;
    num_active = 1'b0;
    num_stage = NUM_IDLE;
    dot_taken = 1'b0;
    rows_done = 8'd0;
    stopped = 1'b0;
    err_flag = 1'b0;
  endfunction

  function automatic fjot_result_t tokenize_byte(input logic [7:0] c, input logic eot);
    fjot_result_t r;
    logic [7:0] lim;
    logic [7:0] row;
    logic [2:0] kind;
    logic [7:0] ch;
    logic digit;
    logic fail;
    logic closed;
    lim = (row_cap > ROW_LIMIT) ? ROW_LIMIT : row_cap;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    kind = K_NONE;
    ch = 8'd0;
    row = rows_done;
    fail = 1'b0;
    closed = 1'b0;
    if (!stopped) begin
      case (parse_phase)
        PH_OUTSIDE: begin
          if (c == CH_QUOTE) begin
            if (rows_done >= lim) fail = 1'b1;
            else parse_phase = PH_KEY;
          end else if (c != CH_SPACE && c != CH_LBRACE && c != CH_RBRACE) begin
            fail = 1'b1;
          end
        end
        PH_KEY: begin
          if (esc_armed) begin
            esc_armed = 1'b0;
            kind = K_KEYCH;
            ch = c;
          end else if (c == CH_BSLASH) begin
            esc_armed = 1'b1;
          end else if (c == CH_QUOTE) begin
            parse_phase = PH_AFTER_KEY;
            kind = K_KEYEND;
          end else begin
            kind = K_KEYCH;
            ch = c;
          end
        end
        PH_AFTER_KEY: begin
          if (c == CH_COLON) parse_phase = PH_COLON;
          else if (c != CH_SPACE) fail = 1'b1;
        end
        PH_COLON: begin
          if (c == CH_QUOTE) begin
            parse_phase = PH_VALUE;
            num_active = 1'b0;
          end else if (c == CH_MINUS || digit) begin
            parse_phase = PH_VALUE;
            num_active = 1'b1;
            num_stage = NUM_DIGITS;
            dot_taken = 1'b0;
            kind = K_VALCH;
            ch = c;
          end else if (c == CH_BSLASH || c == CH_COLON || c == CH_COMMA) begin
            fail = 1'b1;
          end
        end
        PH_VALUE: begin
          if (!num_active) begin
            if (esc_armed) begin
              esc_armed = 1'b0;
              kind = K_VALCH;
              ch = c;
            end else if (c == CH_BSLASH) begin
              esc_armed = 1'b1;
            end else if (c == CH_QUOTE) begin
              parse_phase = PH_AFTER_STR;
              kind = K_STREND;
              rows_done++;
            end else begin
              kind = K_VALCH;
              ch = c;
            end
          end else if (c == CH_COMMA) begin
            parse_phase = PH_OUTSIDE;
            num_active = 1'b0;
            kind = K_NUMEND;
            rows_done++;
          end else if (num_stage == NUM_DIGITS) begin
            if (c == CH_DOT && !dot_taken) begin
              dot_taken = 1'b1;
              kind = K_VALCH;
              ch = c;
            end else if (digit) begin
              kind = K_VALCH;
              ch = c;
            end else if (c == CH_SPACE) begin
              num_stage = NUM_SPACES;
            end else if (c == CH_RBRACE) begin
              kind = K_NUMEND;
              rows_done++;
              closed = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end else if (c != CH_SPACE) begin
            fail = 1'b1;
          end
        end
        PH_AFTER_STR: begin
          if (c == CH_COMMA) parse_phase = PH_OUTSIDE;
          else if (c == CH_RBRACE) closed = 1'b1;
          else if (c != CH_SPACE) fail = 1'b1;
        end
        default: fail = 1'b1;
      endcase
      if (fail) begin
        err_flag = 1'b1;
        stopped = 1'b1;
        kind = K_NONE;
        ch = 8'd0;
      end
      if (closed) stopped = 1'b1;
    end
    r.token_kind = kind;
    r.token_char = ch;
    r.row_index = (kind == K_NONE) ? 7'd0 : row[6:0];
    r.rows_found = rows_done;
    r.parse_error = err_flag;
    r.finished = (stopped && !err_flag) || eot;
    if (eot) clear_parse_state();
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] c, input logic eot);
    text_item_t item;
    item.is_setting = 1'b0;
    item.data = c;
    item.eot = eot;
    text_queue.push_back(item);
  endfunction

  function automatic void push_setting(input logic [7:0] value);
    text_item_t item;
    item.is_setting = 1'b1;
    item.data = value;
    item.eot = 1'b0;
    text_queue.push_back(item);
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] pick_syntax_byte();
    case ($urandom_range(0, 11))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_COLON;
      3: return CH_COMMA;
      4: return CH_RBRACE;
      5: return CH_LBRACE;
      6: return CH_MINUS;
      7: return CH_DOT;
      8: return CH_SPACE;
      9: return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_quoted_text();
    int len;
    int i;
    logic [7:0] c;
    len = $urandom_range(0, 4);
    draft.push_back(CH_QUOTE);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        draft.push_back(CH_BSLASH);
        draft.push_back(8'($urandom));
      end else begin
        do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
        draft.push_back(c);
      end
    end
    draft.push_back(CH_QUOTE);
  endfunction

  function automatic int push_random_object();
    int rows;
    int i;
    int k;
    int cut;
    logic dot;
    logic [7:0] c;
    draft.delete();
    if ($urandom_range(0, 3) == 0) draft.push_back(CH_SPACE);
    draft.push_back(CH_LBRACE);
    rows = $urandom_range(0, 5);
    for (i = 0; i < rows; i++) begin
      add_quoted_text();
      if ($urandom_range(0, 3) == 0) draft.push_back(CH_SPACE);
      draft.push_back(CH_COLON);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (k) begin
        do c = 8'($urandom);
        while (c == CH_QUOTE || c == CH_MINUS || c == CH_BSLASH || c == CH_COLON ||
               c == CH_COMMA || (c >= CH_ZERO && c <= CH_NINE));
        draft.push_back(c);
      end
      if ($urandom_range(0, 1) == 1) begin
        add_quoted_text();
        if ($urandom_range(0, 3) == 0) draft.push_back(CH_SPACE);
      end else begin
        c = ($urandom_range(0, 3) == 0) ? CH_MINUS : 8'(CH_ZERO + $urandom_range(0, 9));
        draft.push_back(c);
        dot = 1'b0;
        repeat ($urandom_range(0, 4)) begin
          if (!dot && $urandom_range(0, 3) == 0) begin
            draft.push_back(CH_DOT);
            dot = 1'b1;
          end else begin
            draft.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          end
        end
        if ((i < rows - 1) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 7) == 0)) begin
          repeat ($urandom_range(1, 2)) draft.push_back(CH_SPACE);
        end
      end
      draft.push_back((i < rows - 1) ? CH_COMMA : CH_RBRACE);
    end
    if (rows == 0) draft.push_back(CH_RBRACE);
    if ($urandom_range(0, 4) == 0) draft.push_back(pick_syntax_byte());
    if ($urandom_range(0, 5) == 0) draft[$urandom_range(0, draft.size() - 1)] = pick_syntax_byte();
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, draft.size());
      draft = draft[0:cut - 1];
    end
    foreach (draft[j]) push_byte(draft[j], j == draft.size() - 1);
    return draft.size();
  endfunction

  function automatic void fill_random(input int target);
    int added;
    int n;
    int i;
    added = 0;
    while (added < target) begin
      if ($urandom_range(0, 11) == 0) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) push_byte(pick_syntax_byte(), i == n - 1);
        added += n;
      end else begin
        added += push_random_object();
      end
    end
  endfunction

  function automatic int pick_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse_state();
      row_cap = MAX_ROWS_RESET;
      in_fire <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_cap = cfg_data;
        items_left--;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_tokens.push_back(tokenize_byte(in_ch.text_byte, in_ch.end_of_text));
        items_left--;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.token_kind, out_ch.token_char, out_ch.row_index, out_ch.rows_found,
               out_ch.parse_error, out_ch.finished};
        if (expected_tokens.size() == 0) begin
          flag_mismatch($sformatf("unexpected token event of kind %0d", got.token_kind));
        end else begin
          want = expected_tokens.pop_front();
          if (got.token_kind !== want.token_kind)
            flag_mismatch($sformatf("event %0d token_kind %0d, expected %0d",
                                    results_taken, got.token_kind, want.token_kind));
          if (got.token_char !== want.token_char)
            flag_mismatch($sformatf("event %0d token_char %0h, expected %0h",
                                    results_taken, got.token_char, want.token_char));
          if (got.row_index !== want.row_index)
            flag_mismatch($sformatf("event %0d row_index %0d, expected %0d",
                                    results_taken, got.row_index, want.row_index));
          if (got.rows_found !== want.rows_found)
            flag_mismatch($sformatf("event %0d rows_found %0d, expected %0d",
                                    results_taken, got.rows_found, want.rows_found));
          if (got.parse_error !== want.parse_error)
            flag_mismatch($sformatf("event %0d parse_error %0b, expected %0b",
                                    results_taken, got.parse_error, want.parse_error));
          if (got.finished !== want.finished)
            flag_mismatch($sformatf("event %0d finished %0b, expected %0b",
                                    results_taken, got.finished, want.finished));
        end
        results_taken++;
      end
      in_fire <= in_ch.valid && in_ch.ready;
      out_fire <= out_ch.valid && out_ch.ready;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      drv_valid = in_ch.valid;
      drv_we = 1'b0;
      if (in_fire) begin
        drv_valid = 1'b0;
        send_gap = pick_gap(send_calm);
      end
      if (!drv_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (text_queue.size() != 0) begin
          if (!text_queue[0].is_setting) begin
            in_ch.text_byte <= text_queue[0].data;
            in_ch.end_of_text <= text_queue[0].eot;
            drv_valid = 1'b1;
            void'(text_queue.pop_front());
          end else if (!in_ch.valid && expected_tokens.size() == 0) begin
            cfg_data <= text_queue[0].data;
            drv_we = 1'b1;
            void'(text_queue.pop_front());
          end
        end
      end
      in_ch.valid <= drv_valid;
      cfg_we <= drv_we;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      next_ready = 1'b1;
      if (out_fire) begin
        recv_gap = pick_gap(recv_calm);
        if (results_taken == 300 || results_taken == 1500) recv_hold = 200;
      end
      if (recv_hold > 0) begin
        next_ready = 1'b0;
        recv_hold--;
      end else if (recv_gap > 0) begin
        next_ready = 1'b0;
        recv_gap--;
      end
      out_ch.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 8'd0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'd0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;

    // Escapes in a key and a string, a brace after a string, then a byte while halted.
    push_text("{\"\\\"\":\"\\\\");
    push_byte(8'hFF, 1'b0);
    push_text("\"}");
    push_byte(8'h00, 1'b1);
    // Ignored bytes outside a pair and after the colon, then a brace after trailing spaces, which is a parse error.
    push_text(" }\"k\" :x-9. ");
    push_byte(CH_RBRACE, 1'b1);
    fill_random(200);

    push_setting(8'd1);
    fill_random(200);

    // An object with the largest row count of pairs, then one key too many.
    push_setting(ROW_LIMIT);
    push_byte(CH_LBRACE, 1'b0);
    repeat (ROW_LIMIT) begin
      push_text("\"\":");
      push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
      push_byte(CH_COMMA, 1'b0);
    end
    push_byte(CH_QUOTE, 1'b0);
    push_byte(8'($urandom), 1'b1);
    fill_random(150);

    push_setting(8'd2);
    fill_random(200);

    push_setting(8'($urandom_range(3, 127)));
    fill_random(230);

    items_left = text_queue.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (items_left != 0 || expected_tokens.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/fjot_pkg.sv
rtl/core/fjot_in_if.sv
rtl/core/fjot_out_if.sv
rtl/core/fjot_step.sv
rtl/core/flat_json_object_tokenizer.sv
sim/testbench.sv
